>>> design/dhcprp_pkg.sv
package dhcprp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic [7:0]  message_type;
        logic [47:0] client_mac;
        logic [31:0] requested_addr;
        logic        requested_valid;
        logic [31:0] server_addr;
        logic        server_valid;
    } t_out_item;

    localparam int unsigned MIN_PACKET_LEN = 244;
    localparam int unsigned POS_OP         = 0;
    localparam int unsigned POS_HTYPE      = 1;
    localparam int unsigned POS_HLEN       = 2;
    localparam int unsigned POS_MAC_FIRST  = 28;
    localparam int unsigned POS_MAC_LAST   = 33;
    localparam int unsigned POS_COOKIE_0   = 236;
    localparam int unsigned POS_COOKIE_1   = 237;
    localparam int unsigned POS_COOKIE_2   = 238;
    localparam int unsigned POS_COOKIE_3   = 239;

    localparam logic [7:0] OP_BOOTREQUEST = 8'd1;
    localparam logic [7:0] HTYPE_ETHERNET = 8'd1;
    localparam logic [7:0] HLEN_MIN       = 8'd6;
    localparam logic [7:0] COOKIE_0       = 8'h63;
    localparam logic [7:0] COOKIE_1       = 8'h82;
    localparam logic [7:0] COOKIE_2       = 8'h53;
    localparam logic [7:0] COOKIE_3       = 8'h63;

    localparam logic [7:0] OPT_PAD        = 8'd0;
    localparam logic [7:0] OPT_END        = 8'd255;
    localparam logic [7:0] OPT_REQ_ADDR   = 8'd50;
    localparam logic [7:0] OPT_MSG_TYPE   = 8'd53;
    localparam logic [7:0] OPT_SERVER_ID  = 8'd54;
    localparam logic [7:0] SIZE_MSG_TYPE  = 8'd1;
    localparam logic [7:0] SIZE_ADDR      = 8'd4;

    localparam logic [7:0] MSG_DISCOVER   = 8'd1;
    localparam logic [7:0] MSG_REQUEST    = 8'd3;

endpackage

>>> design/dhcprp_parse_core.sv
module dhcprp_parse_core
    import dhcprp_pkg::*;
#(
    parameter int unsigned MAX_PACKET_BYTES = 2048
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    output logic      o_done,
    output t_out_item o_result
);

    localparam int unsigned CNT_W = $clog2(MAX_PACKET_BYTES + 1);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CODE,
        PH_SIZE,
        PH_VALUE,
        PH_DONE
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic            r_header_good, n_header_good;
    logic [7:0]      r_opt_code, n_opt_code;
    logic [7:0]      r_opt_size, n_opt_size;
    logic [7:0]      r_opt_left, n_opt_left;
    logic [31:0]     r_pending, n_pending;
    logic [7:0]      r_type, n_type;
    logic [47:0]     r_mac, n_mac;
    logic [31:0]     r_req_addr, n_req_addr;
    logic            r_req_valid, n_req_valid;
    logic [31:0]     r_srv_addr, n_srv_addr;
    logic            r_srv_valid, n_srv_valid;

    logic [7:0]      b;
    logic            good;

    assign b = i_item.data_byte;

    always_comb begin
        n_phase       = r_phase;
        n_count       = r_count;
        n_header_good = r_header_good;
        n_opt_code    = r_opt_code;
        n_opt_size    = r_opt_size;
        n_opt_left    = r_opt_left;
        n_pending     = r_pending;
        n_type        = r_type;
        n_mac         = r_mac;
        n_req_addr    = r_req_addr;
        n_req_valid   = r_req_valid;
        n_srv_addr    = r_srv_addr;
        n_srv_valid   = r_srv_valid;

        if (r_count < CNT_W'(MAX_PACKET_BYTES)) begin
            n_count = r_count + CNT_W'(1);
            case (r_phase)
                PH_HEADER: begin
                    if (r_count == CNT_W'(POS_OP) && b != OP_BOOTREQUEST)
                        n_header_good = 1'b0;
                    if (r_count == CNT_W'(POS_HTYPE) && b != HTYPE_ETHERNET)
                        n_header_good = 1'b0;
                    if (r_count == CNT_W'(POS_HLEN) && b < HLEN_MIN)
                        n_header_good = 1'b0;
                    if (r_count >= CNT_W'(POS_MAC_FIRST) && r_count <= CNT_W'(POS_MAC_LAST))
                        n_mac = {r_mac[39:0], b};
                    if (r_count == CNT_W'(POS_COOKIE_0) && b != COOKIE_0)
                        n_header_good = 1'b0;
                    if (r_count == CNT_W'(POS_COOKIE_1) && b != COOKIE_1)
                        n_header_good = 1'b0;
                    if (r_count == CNT_W'(POS_COOKIE_2) && b != COOKIE_2)
                        n_header_good = 1'b0;
                    if (r_count == CNT_W'(POS_COOKIE_3)) begin
                        if (b != COOKIE_3)
                            n_header_good = 1'b0;
                        n_phase = PH_CODE;
                    end
                end
                PH_CODE: begin
                    if (b == OPT_END) begin
                        n_phase = PH_DONE;
                    end else if (b != OPT_PAD) begin
                        n_opt_code = b;
                        n_phase    = PH_SIZE;
                    end
                end
                PH_SIZE: begin
                    n_opt_size = b;
                    n_opt_left = b;
                    n_pending  = '0;
                    n_phase    = (b == 8'd0) ? PH_CODE : PH_VALUE;
                end
                PH_VALUE: begin
                    n_pending  = {r_pending[23:0], b};
                    n_opt_left = r_opt_left - 8'd1;
                    if (r_opt_left == 8'd1) begin
                        n_phase = PH_CODE;
                        if (r_opt_code == OPT_MSG_TYPE && r_opt_size == SIZE_MSG_TYPE)
                            n_type = b;
                        if (r_opt_code == OPT_REQ_ADDR && r_opt_size == SIZE_ADDR) begin
                            n_req_addr  = n_pending;
                            n_req_valid = 1'b1;
                        end
                        if (r_opt_code == OPT_SERVER_ID && r_opt_size == SIZE_ADDR) begin
                            n_srv_addr  = n_pending;
                            n_srv_valid = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign good   = n_header_good && (n_count >= CNT_W'(MIN_PACKET_LEN));
    assign o_done = i_step && i_item.last_byte;

    always_comb begin
        o_result = '0;
        if (good) begin
            o_result.accepted        = (n_type == MSG_DISCOVER) || (n_type == MSG_REQUEST);
            o_result.message_type    = n_type;
            o_result.client_mac      = n_mac;
            o_result.requested_addr  = n_req_addr;
            o_result.requested_valid = n_req_valid;
            o_result.server_addr     = n_srv_addr;
            o_result.server_valid    = n_srv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_done) begin
            r_phase       <= PH_HEADER;
            r_count       <= '0;
            r_header_good <= 1'b1;
            r_opt_code    <= '0;
            r_opt_size    <= '0;
            r_opt_left    <= '0;
            r_pending     <= '0;
            r_type        <= '0;
            r_mac         <= '0;
            r_req_addr    <= '0;
            r_req_valid   <= 1'b0;
            r_srv_addr    <= '0;
            r_srv_valid   <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_count       <= n_count;
            r_header_good <= n_header_good;
            r_opt_code    <= n_opt_code;
            r_opt_size    <= n_opt_size;
            r_opt_left    <= n_opt_left;
            r_pending     <= n_pending;
            r_type        <= n_type;
            r_mac         <= n_mac;
            r_req_addr    <= n_req_addr;
            r_req_valid   <= n_req_valid;
            r_srv_addr    <= n_srv_addr;
            r_srv_valid   <= n_srv_valid;
        end
    end

endmodule

>>> design/dhcp_request_parser.sv
// dhcp request parser
// input channel: one payload byte per transfer (i_in_valid / o_in_stall),
// with last_byte marking the final byte of a packet
// output channel: one verdict per packet (o_out_valid / i_out_stall),
// carrying accepted, message type, client mac and the two option addresses
// a byte is taken into an input register and parsed from there; the verdict
// for a packet lands in the output register at the edge that ends the parse
// of its final byte, and o_out_valid then stays high until the verdict is taken
// throughput is one byte per cycle while no final byte is held back;
// the only limit is the output register, which holds one verdict
// while the receiver stalls a waiting verdict, ordinary bytes keep flowing;
// only the next final byte waits in the input register, and o_in_stall rises
// until the verdict has been taken
// bytes beyond MAX_PACKET_BYTES are not examined
// reset (synchronous, active low) empties both registers and returns the
// parser to the start of a packet
module dhcp_request_parser
    import dhcprp_pkg::*;
#(
    parameter int unsigned MAX_PACKET_BYTES = 2048
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      step;
    logic      done;
    t_out_item result;

    assign o_in_stall  = r_in_valid && r_in.last_byte && r_out_valid && i_out_stall;
    assign step        = r_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    dhcprp_parse_core #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .o_done   (done),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out <= result;
        end
    end

endmodule

>>> design/dhcprp_checker.sv
module dhcprp_checker
    import dhcprp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // stalled verdict holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled verdict changed");

    // input only backs up behind a stalled verdict
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a waiting verdict");

    a_accept_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.accepted |->
            o_out_data.message_type == MSG_DISCOVER ||
            o_out_data.message_type == MSG_REQUEST)
        else $error("accepted with wrong message type");

    a_addr_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_data.requested_valid || o_out_data.requested_addr == '0) &&
            (o_out_data.server_valid || o_out_data.server_addr == '0))
        else $error("address present without its valid flag");

endmodule

bind dhcp_request_parser dhcprp_checker u_dhcprp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

>>> dv/dhcp_request_parser_test.sv
`timescale 1ns / 1ps

module dhcp_request_parser_test;
    import dhcprp_pkg::*;

    localparam int unsigned PKT_LIMIT   = 2048;
    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int unsigned TAIL_CYCLES = 20;
    localparam logic [31:0] COOKIE      = {COOKIE_0, COOKIE_1, COOKIE_2, COOKIE_3};

    typedef enum logic [2:0] {PH_HEADER, PH_CODE, PH_SIZE, PH_VALUE, PH_DONE} t_phase;
    typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} t_stall;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    dhcp_request_parser #(
        .MAX_PACKET_BYTES(PKT_LIMIT)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #10 clk = ~clk;

    // parser state as seen by the predictor
    int unsigned pkt_pos;
    t_phase      phase;
    logic        hdr_ok;
    logic [7:0]  opt_code;
    logic [7:0]  opt_size;
    logic [7:0]  opt_left;
    logic [31:0] opt_value;
    logic [7:0]  seen_type;
    logic [47:0] seen_mac;
    logic [31:0] seen_req;
    logic        seen_req_ok;
    logic [31:0] seen_srv;
    logic        seen_srv_ok;

    t_out_item   verdicts_due[$];
    logic [7:0]  pkt_bytes[$];
    int unsigned bytes_sent = 0;
    int unsigned burst_left = 0;
    int unsigned errors     = 0;
    int unsigned quiet      = 0;
    int unsigned stall_left = 0;
    int unsigned stall_tick = 0;
    t_stall      stall_mode = STALL_NONE;

    task automatic add_byte(input logic [7:0] b);
        pkt_bytes.insert(pkt_bytes.size(), b);
    endtask

    task automatic clear_parser;
        pkt_pos     = 0;
        phase       = PH_HEADER;
        hdr_ok      = 1'b1;
        opt_code    = '0;
        opt_size    = '0;
        opt_left    = '0;
        opt_value   = '0;
        seen_type   = '0;
        seen_mac    = '0;
        seen_req    = '0;
        seen_req_ok = 1'b0;
        seen_srv    = '0;
        seen_srv_ok = 1'b0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last);
        t_out_item v;
        if (pkt_pos < PKT_LIMIT) begin
            if (phase == PH_HEADER) begin
                if (pkt_pos == POS_OP && b != OP_BOOTREQUEST) hdr_ok = 1'b0;
                if (pkt_pos == POS_HTYPE && b != HTYPE_ETHERNET) hdr_ok = 1'b0;
                if (pkt_pos == POS_HLEN && b < HLEN_MIN) hdr_ok = 1'b0;
                if (pkt_pos >= POS_MAC_FIRST && pkt_pos <= POS_MAC_LAST)
                    seen_mac = {seen_mac[39:0], b};
                if (pkt_pos == POS_COOKIE_0 && b != COOKIE_0) hdr_ok = 1'b0;
                if (pkt_pos == POS_COOKIE_1 && b != COOKIE_1) hdr_ok = 1'b0;
                if (pkt_pos == POS_COOKIE_2 && b != COOKIE_2) hdr_ok = 1'b0;
                if (pkt_pos == POS_COOKIE_3 && b != COOKIE_3) hdr_ok = 1'b0;
                if (pkt_pos == POS_COOKIE_3) phase = PH_CODE;
            end else begin
                case (phase)
                    PH_CODE: begin
                        if (b == OPT_END) begin
                            phase = PH_DONE;
                        end else if (b != OPT_PAD) begin
                            opt_code = b;
                            phase    = PH_SIZE;
                        end
                    end
                    PH_SIZE: begin
                        opt_size  = b;
                        opt_left  = b;
                        opt_value = '0;
                        phase     = (b == 8'd0) ? PH_CODE : PH_VALUE;
                    end
                    PH_VALUE: begin
                        opt_value = {opt_value[23:0], b};
                        opt_left  = opt_left - 8'd1;
                        if (opt_left == 8'd0) begin
                            if (opt_code == OPT_MSG_TYPE && opt_size == SIZE_MSG_TYPE)
                                seen_type = opt_value[7:0];
                            if (opt_code == OPT_REQ_ADDR && opt_size == SIZE_ADDR) begin
                                seen_req    = opt_value;
                                seen_req_ok = 1'b1;
                            end
                            if (opt_code == OPT_SERVER_ID && opt_size == SIZE_ADDR) begin
                                seen_srv    = opt_value;
                                seen_srv_ok = 1'b1;
                            end
                            phase = PH_CODE;
                        end
                    end
                    default: ;
                endcase
            end
            pkt_pos++;
        end
        if (last) begin
            v = '0;
            if (hdr_ok && pkt_pos >= MIN_PACKET_LEN) begin
                v.accepted        = (seen_type == MSG_DISCOVER) || (seen_type == MSG_REQUEST);
                v.message_type    = seen_type;
                v.client_mac      = seen_mac;
                v.requested_addr  = seen_req;
                v.requested_valid = seen_req_ok;
                v.server_addr     = seen_srv;
                v.server_valid    = seen_srv_ok;
            end
            verdicts_due.insert(verdicts_due.size(), v);
            clear_parser();
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 600)
                                                     : $urandom_range(1, 40);
            gap = $urandom_range(0, 12);
            if (gap != 0) begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid          = 1'b1;
        in_data.data_byte = b;
        in_data.last_byte = last;
        do @(posedge clk); while (in_stall);
        parse_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_packet;
        int unsigned n;
        n = pkt_bytes.size();
        for (int unsigned i = 0; i < n; i++) send_byte(pkt_bytes[i], i == n - 1);
    endtask

    task automatic wait_drained;
        @(negedge clk);
        in_valid = 1'b0;
        while (verdicts_due.size() != 0) @(posedge clk);
    endtask

    task automatic start_packet(input logic [7:0] op, htype, hlen, input logic [47:0] mac,
                                input logic [31:0] cookie);
        int k;
        pkt_bytes.delete();
        repeat (POS_COOKIE_3 + 1) add_byte(8'($urandom));
        pkt_bytes[POS_OP]    = op;
        pkt_bytes[POS_HTYPE] = htype;
        pkt_bytes[POS_HLEN]  = hlen;
        for (k = 0; k < 6; k++) pkt_bytes[POS_MAC_FIRST + k] = mac[47 - 8 * k -: 8];
        pkt_bytes[POS_COOKIE_0] = cookie[31:24];
        pkt_bytes[POS_COOKIE_1] = cookie[23:16];
        pkt_bytes[POS_COOKIE_2] = cookie[15:8];
        pkt_bytes[POS_COOKIE_3] = cookie[7:0];
    endtask

    task automatic start_good;
        start_packet(OP_BOOTREQUEST, HTYPE_ETHERNET, HLEN_MIN, 48'({$urandom, $urandom}),
                     COOKIE);
    endtask

    // value bytes go out most significant first; longer options carry random bytes
    task automatic put_opt(input logic [7:0] code, input logic [7:0] size,
                           input logic [31:0] value);
        int k;
        add_byte(code);
        add_byte(size);
        for (k = int'(size) - 1; k >= 0; k--) begin
            if (size <= 8'd4) add_byte(8'(value >> (8 * k)));
            else add_byte(8'($urandom));
        end
    endtask

    task automatic put_typical_body;
        put_opt(OPT_MSG_TYPE, SIZE_MSG_TYPE, 32'(MSG_REQUEST));
        put_opt(OPT_REQ_ADDR, SIZE_ADDR, $urandom);
        put_opt(OPT_SERVER_ID, SIZE_ADDR, $urandom);
        add_byte(OPT_END);
    endtask

    function automatic logic [7:0] pick_kept_code;
        case ($urandom_range(0, 2))
            0: return OPT_MSG_TYPE;
            1: return OPT_REQ_ADDR;
            default: return OPT_SERVER_ID;
        endcase
    endfunction

    task automatic test_header_checks;
        int k;
        start_packet(OP_BOOTREQUEST, HTYPE_ETHERNET, HLEN_MIN, 48'h0, COOKIE);
        put_opt(OPT_MSG_TYPE, SIZE_MSG_TYPE, 32'(MSG_DISCOVER));
        put_opt(OPT_REQ_ADDR, SIZE_ADDR, $urandom);
        add_byte(OPT_END);
        send_packet();
        // exactly the minimum length
        start_packet(OP_BOOTREQUEST, HTYPE_ETHERNET, 8'hff, 48'hffff_ffff_ffff, COOKIE);
        put_opt(OPT_MSG_TYPE, SIZE_MSG_TYPE, 32'(MSG_REQUEST));
        add_byte(OPT_END);
        send_packet();
        start_packet(8'h02, HTYPE_ETHERNET, HLEN_MIN, 48'({$urandom, $urandom}), COOKIE);
        put_typical_body();
        send_packet();
        start_packet(OP_BOOTREQUEST, 8'h06, HLEN_MIN, 48'({$urandom, $urandom}), COOKIE);
        put_typical_body();
        send_packet();
        start_packet(OP_BOOTREQUEST, HTYPE_ETHERNET, 8'h05, 48'({$urandom, $urandom}), COOKIE);
        put_typical_body();
        send_packet();
        for (k = 0; k < 4; k++) begin
            start_packet(OP_BOOTREQUEST, HTYPE_ETHERNET, HLEN_MIN, 48'({$urandom, $urandom}),
                         COOKIE ^ (32'hff << (8 * k)));
            put_typical_body();
            send_packet();
        end
        // one short of the minimum length
        start_good();
        put_opt(OPT_MSG_TYPE, SIZE_MSG_TYPE, 32'(MSG_DISCOVER));
        send_packet();
        start_good();
        send_packet();
        pkt_bytes.delete();
        add_byte(OP_BOOTREQUEST);
        send_packet();
    endtask

    task automatic test_message_types;
        logic [7:0] odd_types[3];
        odd_types = '{8'd2, 8'd0, 8'd255};
        foreach (odd_types[i]) begin
            start_good();
            put_opt(OPT_MSG_TYPE, SIZE_MSG_TYPE, 32'(odd_types[i]));
            put_opt(OPT_SERVER_ID, SIZE_ADDR, $urandom);
            add_byte(OPT_END);
            send_packet();
        end
        // later type replaces earlier
        start_good();
        put_opt(OPT_MSG_TYPE, SIZE_MSG_TYPE, 32'(MSG_DISCOVER));
        put_opt(OPT_MSG_TYPE, SIZE_MSG_TYPE, 32'd8);
        add_byte(OPT_END);
        send_packet();
        // wrong sizes are skipped whole
        start_good();
        put_opt(OPT_MSG_TYPE, SIZE_MSG_TYPE, 32'(MSG_REQUEST));
        put_opt(OPT_MSG_TYPE, 8'd2, 32'h0101);
        put_opt(OPT_MSG_TYPE, 8'd0, 32'd0);
        add_byte(OPT_END);
        send_packet();
        start_good();
        put_opt(OPT_REQ_ADDR, SIZE_ADDR, $urandom);
        put_opt(OPT_SERVER_ID, SIZE_ADDR, $urandom);
        add_byte(OPT_END);
        send_packet();
    endtask

    task automatic test_address_options;
        start_good();
        put_opt(OPT_REQ_ADDR, SIZE_ADDR, 32'hffff_ffff);
        put_opt(OPT_SERVER_ID, SIZE_ADDR, 32'h0);
        put_opt(OPT_MSG_TYPE, SIZE_MSG_TYPE, 32'(MSG_DISCOVER));
        add_byte(OPT_END);
        send_packet();
        start_good();
        put_opt(OPT_MSG_TYPE, SIZE_MSG_TYPE, 32'(MSG_REQUEST));
        add_byte(OPT_PAD);
        add_byte(OPT_PAD);
        put_opt(OPT_REQ_ADDR, 8'd3, $urandom);
        put_opt(OPT_SERVER_ID, 8'd5, $urandom);
        put_opt(OPT_REQ_ADDR, 8'd0, 32'd0);
        put_opt(OPT_SERVER_ID, 8'd0, 32'd0);
        add_byte(OPT_END);
        send_packet();
        // replacement, long unknown option, packet ends on a complete option
        start_good();
        put_opt(OPT_REQ_ADDR, SIZE_ADDR, $urandom);
        put_opt(8'd200, 8'd255, 32'd0);
        put_opt(OPT_REQ_ADDR, SIZE_ADDR, $urandom);
        put_opt(OPT_SERVER_ID, SIZE_ADDR, $urandom);
        send_packet();
        // cut short inside a value
        start_good();
        put_opt(OPT_SERVER_ID, SIZE_ADDR, $urandom);
        add_byte(OPT_REQ_ADDR);
        add_byte(SIZE_ADDR);
        add_byte(8'($urandom));
        add_byte(8'($urandom));
        send_packet();
        // cut short on a code byte
        start_good();
        put_opt(OPT_MSG_TYPE, SIZE_MSG_TYPE, 32'(MSG_DISCOVER));
        add_byte(OPT_MSG_TYPE);
        send_packet();
        // cut short on a size byte
        start_good();
        put_opt(OPT_MSG_TYPE, SIZE_MSG_TYPE, 32'(MSG_REQUEST));
        add_byte(OPT_SERVER_ID);
        add_byte(SIZE_ADDR);
        send_packet();
    endtask

    task automatic test_end_option;
        start_good();
        put_opt(OPT_MSG_TYPE, SIZE_MSG_TYPE, 32'(MSG_REQUEST));
        add_byte(OPT_END);
        put_opt(OPT_MSG_TYPE, SIZE_MSG_TYPE, 32'(MSG_DISCOVER));
        put_opt(OPT_REQ_ADDR, SIZE_ADDR, $urandom);
        send_packet();
        start_good();
        add_byte(OPT_END);
        put_opt(OPT_MSG_TYPE, SIZE_MSG_TYPE, 32'(MSG_DISCOVER));
        put_opt(OPT_SERVER_ID, SIZE_ADDR, $urandom);
        send_packet();
    endtask

    // with no pad the requested address ends on the last examined byte,
    // with one pad it straddles the limit
    task automatic test_overlong;
        int pads;
        for (pads = 0; pads < 2; pads++) begin
            start_good();
            repeat (7) put_opt(8'd200, 8'd255, 32'd0);
            put_opt(OPT_MSG_TYPE, SIZE_MSG_TYPE, 32'(MSG_REQUEST));
            repeat (pads) add_byte(OPT_PAD);
            put_opt(OPT_REQ_ADDR, SIZE_ADDR, $urandom);
            put_opt(OPT_SERVER_ID, SIZE_ADDR, $urandom);
            repeat (10) add_byte(8'($urandom));
            send_packet();
        end
    endtask

    task automatic test_random;
        int unsigned packets;
        int unsigned first_byte;
        int unsigned kind;
        int unsigned len;
        int unsigned s;
        logic [7:0]  op;
        logic [7:0]  htype;
        logic [7:0]  hlen;
        logic [31:0] cookie;
        packets    = 0;
        first_byte = bytes_sent;
        while (packets < 60 || bytes_sent - first_byte < 2000) begin
            kind = $urandom_range(0, 15);
            if (kind == 0) begin
                pkt_bytes.delete();
                repeat ($urandom_range(1, 300)) add_byte(8'($urandom));
            end else begin
                op     = OP_BOOTREQUEST;
                htype  = HTYPE_ETHERNET;
                hlen   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(6, 255)) : HLEN_MIN;
                cookie = COOKIE;
                if (kind == 1) begin
                    case ($urandom_range(0, 3))
                        0: op = 8'($urandom);
                        1: htype = 8'($urandom);
                        2: hlen = 8'($urandom_range(0, 5));
                        default: cookie = cookie ^ (32'd1 << $urandom_range(0, 31));
                    endcase
                end
                start_packet(op, htype, hlen, 48'({$urandom, $urandom}), cookie);
                repeat ($urandom_range(0, 8)) begin
                    case ($urandom_range(0, 8))
                        0, 1: put_opt(OPT_MSG_TYPE, SIZE_MSG_TYPE,
                                      $urandom_range(0, 1) ?
                                      ($urandom_range(0, 1) ? 32'(MSG_DISCOVER)
                                                            : 32'(MSG_REQUEST))
                                      : 32'($urandom_range(0, 255)));
                        2: put_opt(OPT_REQ_ADDR, SIZE_ADDR, $urandom);
                        3: put_opt(OPT_SERVER_ID, SIZE_ADDR, $urandom);
                        4: repeat ($urandom_range(1, 3)) add_byte(OPT_PAD);
                        5: put_opt(pick_kept_code(), 8'($urandom_range(0, 6)), $urandom);
                        6, 7: put_opt(8'($urandom_range(1, 254)),
                                      ($urandom_range(0, 15) == 0) ? 8'($urandom)
                                                                   : 8'($urandom_range(0, 8)),
                                      $urandom);
                        default: put_opt(8'($urandom_range(1, 254)), 8'd0, 32'd0);
                    endcase
                end
                case ($urandom_range(0, 5))
                    0, 1: begin
                        add_byte(OPT_END);
                        repeat ($urandom_range(0, 8)) add_byte(8'($urandom));
                    end
                    2: begin
                        add_byte(pick_kept_code());
                        if ($urandom_range(0, 1)) begin
                            s = $urandom_range(1, 8);
                            add_byte(8'(s));
                            repeat ($urandom_range(0, s - 1)) add_byte(8'($urandom));
                        end
                    end
                    3: begin
                        len = $urandom_range(230, pkt_bytes.size());
                        while (pkt_bytes.size() > len) void'(pkt_bytes.pop_back());
                    end
                    default: ;
                endcase
            end
            send_packet();
            packets++;
            if (packets % 20 == 19) wait_drained();
        end
    endtask

    // receiver stall pattern
    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            STALL_NONE:  out_stall = 1'b0;
            STALL_COIN:  out_stall = 1'($urandom_range(0, 1));
            STALL_HEAVY: out_stall = ($urandom_range(0, 7) != 0);
            default:     out_stall = (stall_tick % 5) < 2;
        endcase
    end

    always @(posedge clk) begin : check_verdict
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (verdicts_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected verdict transfer: %h", out_data);
            end else begin
                want = verdicts_due.pop_front();
                if (out_data.accepted !== want.accepted ||
                    out_data.message_type !== want.message_type ||
                    out_data.client_mac !== want.client_mac ||
                    out_data.requested_addr !== want.requested_addr ||
                    out_data.requested_valid !== want.requested_valid ||
                    out_data.server_addr !== want.server_addr ||
                    out_data.server_valid !== want.server_valid) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("verdict mismatch: want acc %b type %h mac %h req %h/%b srv %h/%b",
                                 want.accepted, want.message_type, want.client_mac,
                                 want.requested_addr, want.requested_valid,
                                 want.server_addr, want.server_valid);
                        $display("                  got  acc %b type %h mac %h req %h/%b srv %h/%b",
                                 out_data.accepted, out_data.message_type, out_data.client_mac,
                                 out_data.requested_addr, out_data.requested_valid,
                                 out_data.server_addr, out_data.server_valid);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
            else quiet++;
            if (quiet == QUIET_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        clear_parser();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        test_header_checks();
        test_message_types();
        wait_drained();
        test_address_options();
        test_end_option();
        test_overlong();
        wait_drained();
        test_random();
        @(negedge clk);
        in_valid = 1'b0;
        while (verdicts_due.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
design/dhcprp_pkg.sv
design/dhcprp_parse_core.sv
design/dhcp_request_parser.sv
design/dhcprp_checker.sv
dv/dhcp_request_parser_test.sv
